// ===== rtl/nmea_gga_position_parser_core_defines.svh =====
// Assertion macros used by the parser's checker file.
`ifndef NMEA_GGA_POSITION_PARSER_CORE_DEFINES_SVH
`define NMEA_GGA_POSITION_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ngp checker: property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NGP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ngp checker: property failed");

`endif

// ===== rtl/ngp_pkg.sv =====
// Types, constants and helper functions of the GGA position parser.
package ngp_pkg;

  localparam int MAX_LINE    = 128;
  localparam int FRAC_DIGITS = 5;
  localparam int FRAC_W      = 17;
  localparam int HDR_LEN     = 6;
  localparam int NSTAGE      = 7;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // floor(2^38 / 100) and floor(2^37 / 60): estimates are low by at most one
  localparam logic [31:0] DIV100_M = 32'd2748779069;
  localparam logic [31:0] DIV60_M  = 32'd2290649224;

  localparam logic [31:0] LAT_LIMIT = 32'd900000000;
  localparam logic [31:0] LON_LIMIT = 32'd1800000000;

  typedef enum logic [1:0] {
    LM_HDR  = 2'd0,
    LM_GGA  = 2'd1,
    LM_SKIP = 2'd2
  } line_mode_t;

  typedef struct packed {
    logic [31:0]       int_val;
    logic [FRAC_W-1:0] frac_val;
    logic [2:0]        frac_digits;
    logic              neg;
  } lane_job_t;

  typedef struct packed {
    logic                ok;
    lane_job_t [1:0]     lane;
  } job_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24; // $
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h4E; // N
      3'd3:    c = 8'h47; // G
      3'd4:    c = 8'h47; // G
      3'd5:    c = 8'h41; // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // 10^(7 - digits): scales the fraction to 1e-7 minute units
  function automatic logic [23:0] frac_scale(input logic [2:0] digits);
    logic [23:0] s;
    case (digits)
      3'd0:    s = 24'd10000000;
      3'd1:    s = 24'd1000000;
      3'd2:    s = 24'd100000;
      3'd3:    s = 24'd10000;
      3'd4:    s = 24'd1000;
      3'd5:    s = 24'd100;
      3'd6:    s = 24'd10;
      default: s = 24'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ngp_fifo.sv =====
// Short job queue between the line parser and the conversion pipeline.
module ngp_fifo
  import ngp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/ngp_front.sv =====
// Line parser: header match, comma count and coordinate field capture.
module ngp_front
  import ngp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output logic       push,
  output job_t       job
);

  line_mode_t mode_r, mode_nxt;
  logic [2:0] hcnt_r, hcnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [3:0] cc_r, cc_nxt;

  logic [31:0]       int_val_r [2];
  logic [31:0]       int_val_nxt [2];
  logic [3:0]        int_dig_r [2];
  logic [3:0]        int_dig_nxt [2];
  logic [FRAC_W-1:0] frac_val_r [2];
  logic [FRAC_W-1:0] frac_val_nxt [2];
  logic [2:0]        frac_dig_r [2];
  logic [2:0]        frac_dig_nxt [2];
  logic              point_r [2];
  logic              point_nxt [2];
  logic              hemi_r [2];
  logic              hemi_nxt [2];
  logic              neg_r [2];
  logic              neg_nxt [2];

  logic       take;
  logic       is_nl;
  logic       is_comma;
  logic       is_digit;
  logic       at_limit;
  logic       hdr_hit;
  logic [3:0] digit;
  logic [1:0] fld_ok;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;
  assign is_nl     = (in_tdata == CH_NL);
  assign is_comma  = (in_tdata == CH_COMMA);
  assign is_digit  = (in_tdata inside {[8'h30:8'h39]});
  assign digit     = in_tdata[3:0];
  assign at_limit  = (len_r >= 8'(MAX_LINE));
  assign hdr_hit   = (hcnt_r < 3'(HDR_LEN)) && (in_tdata == hdr_char(hcnt_r));

  always_comb begin : mode_next
    mode_nxt = mode_r;
    if (take) begin
      if (is_nl) begin
        mode_nxt = LM_HDR;
      end else if (!at_limit) begin
        case (mode_r)
          LM_HDR: begin
            if (!hdr_hit) begin
              mode_nxt = LM_SKIP;
            end else if (hcnt_r == 3'(HDR_LEN - 1)) begin
              mode_nxt = LM_GGA;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin : field_next
    logic [35:0] acc;
    hcnt_nxt = hcnt_r;
    len_nxt  = len_r;
    cc_nxt   = cc_r;
    push     = 1'b0;
    acc      = '0;
    for (int j = 0; j < 2; j++) begin
      int_val_nxt[j]  = int_val_r[j];
      int_dig_nxt[j]  = int_dig_r[j];
      frac_val_nxt[j] = frac_val_r[j];
      frac_dig_nxt[j] = frac_dig_r[j];
      point_nxt[j]    = point_r[j];
      hemi_nxt[j]     = hemi_r[j];
      neg_nxt[j]      = neg_r[j];
    end
    if (take) begin
      if (is_nl) begin
        push     = (mode_r == LM_GGA);
        hcnt_nxt = '0;
        len_nxt  = '0;
        cc_nxt   = '0;
        for (int j = 0; j < 2; j++) begin
          int_val_nxt[j]  = '0;
          int_dig_nxt[j]  = '0;
          frac_val_nxt[j] = '0;
          frac_dig_nxt[j] = '0;
          point_nxt[j]    = 1'b0;
          hemi_nxt[j]     = 1'b0;
          neg_nxt[j]      = 1'b0;
        end
      end else if (!at_limit) begin
        len_nxt = len_r + 8'd1;
        if (mode_r == LM_HDR && hdr_hit) begin
          hcnt_nxt = hcnt_r + 3'd1;
        end
        if (mode_r == LM_GGA) begin
          if (is_comma) begin
            if (cc_r != 4'hF) begin
              cc_nxt = cc_r + 4'd1;
            end
          end else begin
            for (int j = 0; j < 2; j++) begin
              // latitude after comma two, longitude after comma four
              if (cc_r == 4'(2 + 2*j)) begin
                if (is_digit) begin
                  if (!point_r[j]) begin
                    acc = 36'(int_val_r[j]) * 36'd10 + 36'(digit);
                    int_val_nxt[j] = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc[31:0];
                    if (int_dig_r[j] != 4'hF) begin
                      int_dig_nxt[j] = int_dig_r[j] + 4'd1;
                    end
                  end else if (frac_dig_r[j] < 3'(FRAC_DIGITS)) begin
                    frac_val_nxt[j] = FRAC_W'(frac_val_r[j] * FRAC_W'(10))
                                      + FRAC_W'(digit);
                    frac_dig_nxt[j] = frac_dig_r[j] + 3'd1;
                  end
                end else if (in_tdata == CH_POINT) begin
                  point_nxt[j] = 1'b1;
                end
              end
              // hemisphere: first character only
              if (cc_r == 4'(3 + 2*j) && !hemi_r[j]) begin
                hemi_nxt[j] = 1'b1;
                neg_nxt[j]  = (in_tdata == CH_S) || (in_tdata == CH_W);
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      fld_ok[j]                = point_r[j] && (int_dig_r[j] >= 4'd2) && hemi_r[j];
      job.lane[j].int_val     = int_val_r[j];
      job.lane[j].frac_val    = frac_val_r[j];
      job.lane[j].frac_digits = frac_dig_r[j];
      job.lane[j].neg         = neg_r[j];
    end
    job.ok = &fld_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LM_HDR;
      hcnt_r <= '0;
      len_r  <= '0;
      cc_r   <= '0;
      for (int j = 0; j < 2; j++) begin
        int_val_r[j]  <= '0;
        int_dig_r[j]  <= '0;
        frac_val_r[j] <= '0;
        frac_dig_r[j] <= '0;
        point_r[j]    <= 1'b0;
        hemi_r[j]     <= 1'b0;
        neg_r[j]      <= 1'b0;
      end
    end else begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      len_r  <= len_nxt;
      cc_r   <= cc_nxt;
      for (int j = 0; j < 2; j++) begin
        int_val_r[j]  <= int_val_nxt[j];
        int_dig_r[j]  <= int_dig_nxt[j];
        frac_val_r[j] <= frac_val_nxt[j];
        frac_dig_r[j] <= frac_dig_nxt[j];
        point_r[j]    <= point_nxt[j];
        hemi_r[j]     <= hemi_nxt[j];
        neg_r[j]      <= neg_nxt[j];
      end
    end
  end

endmodule

// ===== rtl/ngp_lane.sv =====
// One coordinate conversion lane: ddmm.mmmmm to signed 1e-7 degrees, seven stages.
module ngp_lane
  import ngp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  lane_job_t   job,
  input  logic [31:0] limit,
  output logic [31:0] res
);

  // stage 1: reciprocal product for /100, fraction scaling
  logic [63:0] s1_p_r;
  logic [31:0] s1_x_r;
  logic [23:0] s1_fp_r;
  logic        s1_neg_r;
  // stage 2: quotient estimate times 100
  logic [25:0] s2_q0_r;
  logic [31:0] s2_qm_r;
  logic [31:0] s2_x_r;
  logic [23:0] s2_fp_r;
  logic        s2_neg_r;
  // stage 3: corrected degrees and minutes
  logic [25:0] s3_q_r;
  logic [6:0]  s3_r_r;
  logic [23:0] s3_fp_r;
  logic        s3_neg_r;
  // stage 4: minutes in 1e-7 units plus rounding, degrees times 1e7
  logic [29:0] s4_y_r;
  logic [48:0] s4_deg_r;
  logic        s4_neg_r;
  // stage 5: reciprocal product for /60
  logic [61:0] s5_p_r;
  logic [29:0] s5_y_r;
  logic [48:0] s5_deg_r;
  logic        s5_neg_r;
  // stage 6: quotient estimate times 60
  logic [24:0] s6_q2_r;
  logic [30:0] s6_q2m_r;
  logic [29:0] s6_y_r;
  logic [48:0] s6_deg_r;
  logic        s6_neg_r;
  // stage 7: corrected sum
  logic [48:0] s7_v_r;
  logic        s7_neg_r;

  logic [31:0] d1;
  logic [7:0]  r1;
  logic [29:0] d2;
  logic [24:0] q2c;
  logic [31:0] mag;

  assign d1  = s2_x_r - s2_qm_r;
  assign r1  = d1[7:0];
  assign d2  = s6_y_r - s6_q2m_r[29:0];
  assign q2c = s6_q2_r + 25'(d2 >= 30'd60);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r   <= 64'(job.int_val) * 64'(DIV100_M);
      s1_x_r   <= job.int_val;
      s1_fp_r  <= 24'(job.frac_val) * frac_scale(job.frac_digits);
      s1_neg_r <= job.neg;

      s2_q0_r  <= s1_p_r[63:38];
      s2_qm_r  <= 32'(s1_p_r[63:38]) * 32'd100;
      s2_x_r   <= s1_x_r;
      s2_fp_r  <= s1_fp_r;
      s2_neg_r <= s1_neg_r;

      // estimate may be one low: step once
      if (r1 >= 8'd100) begin
        s3_q_r <= s2_q0_r + 26'd1;
        s3_r_r <= 7'(r1 - 8'd100);
      end else begin
        s3_q_r <= s2_q0_r;
        s3_r_r <= r1[6:0];
      end
      s3_fp_r  <= s2_fp_r;
      s3_neg_r <= s2_neg_r;

      s4_y_r   <= 30'(s3_r_r) * 30'd10000000 + 30'(s3_fp_r) + 30'd30;
      s4_deg_r <= 49'(s3_q_r) * 49'd10000000;
      s4_neg_r <= s3_neg_r;

      s5_p_r   <= 62'(s4_y_r) * 62'(DIV60_M);
      s5_y_r   <= s4_y_r;
      s5_deg_r <= s4_deg_r;
      s5_neg_r <= s4_neg_r;

      s6_q2_r  <= s5_p_r[61:37];
      s6_q2m_r <= 31'(s5_p_r[61:37]) * 31'd60;
      s6_y_r   <= s5_y_r;
      s6_deg_r <= s5_deg_r;
      s6_neg_r <= s5_neg_r;

      s7_v_r   <= s6_deg_r + 49'(q2c);
      s7_neg_r <= s6_neg_r;
    end
  end

  assign mag = (s7_v_r > 49'(limit)) ? limit : s7_v_r[31:0];
  assign res = s7_neg_r ? (32'd0 - mag) : mag;

endmodule

// ===== rtl/ngp_back.sv =====
// Conversion back end: two lanes, valid pipeline, held fix and output register.
module ngp_back
  import ngp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_lock,
  output logic [30:0] out_lat,
  output logic [31:0] out_lon
);

  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE-1:0] ok_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_lock_r;
  logic [30:0]       out_lat_r;
  logic [31:0]       out_lon_r;
  logic [30:0]       held_lat_r, held_lat_nxt;
  logic [31:0]       held_lon_r, held_lon_nxt;
  logic              en;
  logic              fin;
  logic [31:0]       lat_res;
  logic [31:0]       lon_res;

  // advance the whole pipeline whenever the output slot frees up
  assign en  = !out_valid_r || out_tready;
  assign pop = en && !q_empty;
  assign fin = vld_r[NSTAGE-1];

  ngp_lane u_lat (
    .clk   (clk),
    .en    (en),
    .job   (head.lane[0]),
    .limit (LAT_LIMIT),
    .res   (lat_res)
  );

  ngp_lane u_lon (
    .clk   (clk),
    .en    (en),
    .job   (head.lane[1]),
    .limit (LON_LIMIT),
    .res   (lon_res)
  );

  always_comb begin
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    held_lat_nxt  = held_lat_r;
    held_lon_nxt  = held_lon_r;
    if (en) begin
      vld_nxt       = {vld_r[NSTAGE-2:0], !q_empty};
      out_valid_nxt = fin;
      if (fin && ok_r[NSTAGE-1]) begin
        held_lat_nxt = lat_res[30:0];
        held_lon_nxt = lon_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      held_lat_r  <= '0;
      held_lon_r  <= '0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      held_lat_r  <= held_lat_nxt;
      held_lon_r  <= held_lon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r       <= {ok_r[NSTAGE-2:0], head.ok};
      out_lock_r <= ok_r[NSTAGE-1];
      out_lat_r  <= held_lat_nxt;
      out_lon_r  <= held_lon_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_lock   = out_lock_r;
  assign out_lat    = out_lat_r;
  assign out_lon    = out_lon_r;

endmodule

// ===== rtl/nmea_gga_position_parser_core.sv =====
// Top level of the GGA position parser: front parser, job queue, conversion back end.
//
// Usage: feed the received NMEA stream one character per word on the in_ channel
// (in_tdata[7:0]). The block takes a word in every cycle while in_tready is high;
// in_tready only drops when the four-entry job queue is full.
// A line that starts with $GNGGA produces one word on the out_ channel at its
// newline: out_tuser is the lock flag, out_tdata carries latitude and longitude
// in 1e-7 degrees (south and west negative). Without a lock the last good
// coordinates are repeated. Other lines produce nothing.
// The result passes through the job queue, the seven-stage conversion pipeline
// and the output register before it shows on out_tvalid.
// Throughput: one character per cycle while in_tready is high, one result per cycle.
// When the receiver stalls, the whole conversion pipeline holds; lines keep
// being parsed until four finished lines wait in the queue, then in_tready drops.
// Reset clears the line state and the held coordinates (to zero), not the lock.
module nmea_gga_position_parser_core
  import ngp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [30:0] latitude, [62:31] longitude, [63] zero
  output logic        out_tuser   // [0] fix_lock
);

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  job_t        job_in;
  job_t        job_head;
  logic        lock;
  logic [30:0] lat;
  logic [31:0] lon;

  ngp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .job       (job_in)
  );

  ngp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_in),
    .full  (q_full),
    .pop   (pop),
    .dout  (job_head),
    .empty (q_empty)
  );

  ngp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (job_head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_lock   (lock),
    .out_lat    (lat),
    .out_lon    (lon)
  );

  assign out_tdata = {1'b0, lon, lat};
  assign out_tuser = lock;

endmodule

// ===== rtl/ngp_checker.sv =====
// Port-level checker for the GGA position parser, bound to the top level.
`include "nmea_gga_position_parser_core_defines.svh"

module ngp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  logic [64:0]        out_word;
  logic signed [30:0] lat;
  logic signed [31:0] lon;

  assign out_word = {out_tuser, out_tdata};
  assign lat      = out_tdata[30:0];
  assign lon      = out_tdata[62:31];

  `NGP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  `NGP_ASSERT_IMP(a_lat_range, out_tvalid, lat >= -31'sd900000000 && lat <= 31'sd900000000)

  `NGP_ASSERT_IMP(a_lon_range, out_tvalid, lon >= -32'sd1800000000 && lon <= 32'sd1800000000)

  `NGP_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[63] == 1'b0)

endmodule

bind nmea_gga_position_parser_core ngp_checker u_ngp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench of the GGA position parser: directed and random NMEA lines against a predictor.
`timescale 1ns / 1ps

module tb;
  import ngp_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          BYTE_GOAL      = 1800;
  localparam int          GGA_GOAL       = 10;
  localparam logic [47:0] GGA_TAG        = "$GNGGA";
  localparam logic [7:0]  DIGIT_0        = 8'h30;
  localparam logic [7:0]  DIGIT_9        = 8'h39;

  typedef struct packed {
    logic        lock;
    logic [30:0] lat;
    logic [31:0] lon;
  } fix_t;

  typedef struct packed {
    logic [7:0] data;
    logic       settle;  // hold until every fix report is back
  } rx_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  nmea_gga_position_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  rx_word_t rx_words[$];
  fix_t     fixes_due[$];
  logic     all_fixes_in = 1'b1;
  bit       settle_next  = 1'b0;
  int       mismatches   = 0;
  int       bytes_taken  = 0;
  int       fixes_seen   = 0;
  int       locks_seen   = 0;
  int       gga_lines    = 0;
  int       idle_cycles  = 0;
  int       tx_gap       = 0;
  int       tx_calm      = 0;
  int       rx_stall     = 0;
  int       rx_calm      = 0;

  // ---------------------------------------------------------------- predictor state
  logic [2:0]  hdr_seen;
  line_mode_t  mode;
  logic [7:0]  line_len;
  logic [3:0]  n_commas;
  logic [31:0] int_val   [2];
  logic [3:0]  int_cnt   [2];
  logic [16:0] frac_val  [2];
  logic [2:0]  frac_cnt  [2];
  logic        point_seen[2];
  logic        hemi_set  [2];
  logic        hemi_neg  [2];
  logic [31:0] fix_lat = '0;
  logic [31:0] fix_lon = '0;

  function automatic void clear_line();
    hdr_seen = '0;
    mode     = LM_HDR;
    line_len = '0;
    n_commas = '0;
    for (int k = 0; k < 2; k++) begin
      int_val[k]    = '0;
      int_cnt[k]    = '0;
      frac_val[k]   = '0;
      frac_cnt[k]   = '0;
      point_seen[k] = 1'b0;
      hemi_set[k]   = 1'b0;
      hemi_neg[k]   = 1'b0;
    end
  endfunction

  function automatic bit coord_valid(input int k);
    return point_seen[k] && int_cnt[k] >= 2 && hemi_set[k];
  endfunction

  // ddmm.mmmmm to signed 1e-7 degrees, minutes divided by 60 rounding half up
  function automatic logic [31:0] to_units(input int k, input logic [31:0] limit);
    logic [63:0] deg, mins, scale, m7, v;
    logic [31:0] mag;
    deg   = 64'(int_val[k]) / 100;
    mins  = 64'(int_val[k]) % 100;
    scale = 64'd1;
    for (int i = int'(frac_cnt[k]); i < 7; i++) scale = scale * 10;
    m7 = mins * 64'd10000000 + 64'(frac_val[k]) * scale;
    v  = deg * 64'd10000000 + (m7 + 64'd30) / 64'd60;
    if (v > 64'(limit)) v = 64'(limit);
    mag = v[31:0];
    return hemi_neg[k] ? 32'd0 - mag : mag;
  endfunction

  function automatic bit parse_byte(input logic [7:0] c, output fix_t rpt);
    int          k;
    logic [63:0] acc;
    bit          ok;
    rpt = '0;
    if (c == CH_NL) begin
      ok = 1'b0;
      if (mode == LM_GGA) begin
        ok = coord_valid(0) && coord_valid(1);
        if (ok) begin
          fix_lat = to_units(0, LAT_LIMIT);
          fix_lon = to_units(1, LON_LIMIT);
        end
        rpt.lock = ok;
        rpt.lat  = fix_lat[30:0];
        rpt.lon  = fix_lon;
        clear_line();
        return 1'b1;
      end
      clear_line();
      return 1'b0;
    end
    if (int'(line_len) >= MAX_LINE) return 1'b0;
    line_len = line_len + 8'd1;
    if (mode == LM_HDR) begin
      if (hdr_seen < HDR_LEN && c == GGA_TAG[8 * (5 - int'(hdr_seen)) +: 8]) begin
        hdr_seen = hdr_seen + 3'd1;
        if (hdr_seen == HDR_LEN) mode = LM_GGA;
      end else begin
        mode = LM_SKIP;
      end
      return 1'b0;
    end
    if (mode != LM_GGA) return 1'b0;
    if (c == CH_COMMA) begin
      if (n_commas != 4'd15) n_commas = n_commas + 4'd1;
      return 1'b0;
    end
    if (n_commas == 2 || n_commas == 4) begin
      k = (n_commas == 2) ? 0 : 1;
      if (c >= DIGIT_0 && c <= DIGIT_9) begin
        if (!point_seen[k]) begin
          acc        = 64'(int_val[k]) * 10 + 64'(c - DIGIT_0);
          int_val[k] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
          if (int_cnt[k] != 4'd15) int_cnt[k] = int_cnt[k] + 4'd1;
        end else if (int'(frac_cnt[k]) < FRAC_DIGITS) begin
          frac_val[k] = frac_val[k] * 17'd10 + 17'(c - DIGIT_0);
          frac_cnt[k] = frac_cnt[k] + 3'd1;
        end
      end else if (c == CH_POINT) begin
        point_seen[k] = 1'b1;
      end
    end else if (n_commas == 3 || n_commas == 5) begin
      k = (n_commas == 3) ? 0 : 1;
      if (!hemi_set[k]) begin
        hemi_set[k] = 1'b1;
        hemi_neg[k] = (c == CH_S || c == CH_W);
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_word_t w;
    w.data      = b;
    w.settle    = settle_next;
    settle_next = 1'b0;
    rx_words.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // mostly a well-formed coordinate, now and then short, long or with junk
  function automatic string coord_text(input int deg_digits);
    string s;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 80) s = rand_digits(deg_digits + 2);
    else if (r < 88) s = rand_digits($urandom_range(0, 1));
    else s = rand_digits($urandom_range(3, 12));
    if ($urandom_range(0, 9) != 0) begin
      s = {s, "."};
      if ($urandom_range(0, 2) != 0) s = {s, rand_digits(5)};
      else s = {s, rand_digits($urandom_range(0, 8))};
    end
    if ($urandom_range(0, 19) == 0)
      s = {s, $sformatf("%c", $urandom_range(33, 126)), rand_digits($urandom_range(0, 3))};
    return s;
  endfunction

  function automatic string hemi_text(input bit lon);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return lon ? "E" : "N";
    if (r < 90) return lon ? "W" : "S";
    if (r < 95) return "";
    return $sformatf("%c%c", $urandom_range(33, 126), $urandom_range(33, 126));
  endfunction

  function automatic string sep();
    return ($urandom_range(0, 39) == 0) ? "" : ",";
  endfunction

  task automatic push_random_line();
    string s;
    int    r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0) settle_next = 1'b1;
    if (r < 78) begin
      gga_lines++;
      s = {"$GNGGA", sep()};
      if ($urandom_range(0, 1)) s = {s, rand_digits(6), ".00"};
      // pad the time field past the line limit to drop the coordinates
      if (r >= 74) s = {s, rand_digits($urandom_range(120, 140))};
      s = {s, sep(), coord_text(2), sep(), hemi_text(0), sep(), coord_text(3), sep(),
           hemi_text(1)};
      if ($urandom_range(0, 2) == 0) s = {s, ",1,08,0.9,545.4,M,46.9,M,,"};
      if (r >= 70 && r < 74) s = {s, ",", rand_digits($urandom_range(100, 150))};
      push_text({s, "\n"});
    end else if (r < 88) begin
      case ($urandom_range(0, 5))
        0:       s = "$GPGGA";
        1:       s = "$GNRMC";
        2:       s = "$GNGG";
        3:       s = "$GNGGB";
        4:       s = "GNGGA";
        default: s = "$$GNGGA";
      endcase
      push_text({s, ",,4807.038,N,01131.000,E\n"});
    end else begin
      repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_NL);
    end
  endtask

  // ---------------------------------------------------------------- sender
  always @(posedge clk) begin : driver
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (rx_words.size() != 0 &&
                     (!rx_words[0].settle || (!in_tvalid && all_fixes_in))) begin
          nxt_data  = rx_words[0].data;
          nxt_valid = 1'b1;
          void'(rx_words.pop_front());
          if (tx_calm > 0) begin
            tx_calm--;
          end else if ($urandom_range(0, 49) == 0) begin
            tx_calm = $urandom_range(30, 200);
          end else begin
            tx_gap = pause_len();
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
  end

  // ---------------------------------------------------------------- receiver stalls
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(30, 200);
      else rx_stall = pause_len();
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    fix_t rpt;
    fix_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        bytes_taken++;
        if (parse_byte(in_tdata, rpt)) fixes_due.push_back(rpt);
      end
      if (out_tvalid && out_tready) begin
        fixes_seen++;
        if (out_tuser === 1'b1) locks_seen++;
        if (fixes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual lock %b data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = fixes_due.pop_front();
          if ({out_tuser, out_tdata} !== {want.lock, 1'b0, want.lon, want.lat}) begin
            check_field("fix_lock", want.lock, out_tuser);
            check_field("latitude", $signed(want.lat), $signed(out_tdata[30:0]));
            check_field("longitude", $signed(want.lon), $signed(out_tdata[62:31]));
            check_field("pad bit", 0, out_tdata[63]);
            if ($isunknown({out_tuser, out_tdata})) begin
              mismatches++;
              $display("%0t: unknown bits: expected %h, actual %h", $time,
                       {want.lock, 1'b0, want.lon, want.lat}, {out_tuser, out_tdata});
            end
          end
        end
      end
      all_fixes_in <= (fixes_due.size() == 0);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    string pad;
    clear_line();

    push_text("$GNGGA,123519.00,4807.03800,N,01131.00000,E,1,08,0.9,545.4,M,46.9,M,,\n");
    push_text("$GNGGA,,0000.00000,N,00000.00000,E\n");
    push_text("$GNGGA,,9959.99999,S,17959.99999,W\n");
    push_text("$GNGGA,,9000.0,N,18000.0,E\n");
    push_text("$GNGGA,,99999.99999,S,99999.99999,W\n");
    push_text("$GNGGA,,99999999999.1,N,1234567890123456789.9,W\n");
    push_text("$GNGGA,,5.0,N,01131.0,E\n");
    push_text("$GNGGA,,4807,N,01131.0,E\n");
    push_text("$GNGGA,,4807.0381234,N,01131.1234567,E\n");
    push_text("$GNGGA,,48x07.0.38,N,011a31.00.5,E\n");
    push_text("$GNGGA,,4807.038,North,01131.000,Q\n");
    push_text("$GNGGA,,4807.038,,01131.000,E\n");
    push_text("$GNGGA,4807.038,N,01131.000,E\n");
    push_text("$GNGGA,,.5,S,01.,W\n");
    push_text("$GNGGA,,10.,S,00.,W\n");
    push_text("$GPGGA,,4807.038,N,01131.000,E\n");
    push_text("$GNG\n");
    push_text("\n");
    push_text("$GNGGA\n");
    push_text("xx$GNGGA,,4807.038,N,01131.000,E\n");
    push_text("$GNGGA,,0030.00003,N,00000.00001,W\n");
    push_text("$GNGGA,,,,,,,,,,,,,,,,,,,,,1234.5\n");
    pad = "";
    repeat (130) pad = {pad, "x"};
    // coordinates inside the limit, the rest of the line dropped
    push_text({"$GNGGA,,4807.038,S,01131.000,W,", pad, "\n"});
    // coordinates beyond the limit are never seen
    push_text({"$GNGGA,", pad, ",4807.038,N,01131.000,E\n"});
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(CH_NL);

    // first random line waits until the directed reports are all back
    settle_next = 1'b1;
    while (rx_words.size() < BYTE_GOAL || gga_lines < GGA_GOAL) push_random_line();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (rx_words.size() != 0 || in_tvalid || fixes_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fixes_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d fix reports expected, actual none", $time, fixes_due.size());
    end
    $display("tb: %0d characters parsed, %0d GGA reports checked (%0d locked)",
             bytes_taken, fixes_seen, locks_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ngp_pkg.sv
rtl/ngp_fifo.sv
rtl/ngp_front.sv
rtl/ngp_lane.sv
rtl/ngp_back.sv
rtl/nmea_gga_position_parser_core.sv
rtl/ngp_checker.sv
tb/tb.sv
